[rtl/tzhq_pkg.sv]
`timescale 1ns / 1ps
// tzhq_pkg: widths, constants, reset values and shared types of the touch zone hold qualifier
// used by every file under rtl; depends on nothing

package tzhq_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int BYTE_W         = 8;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int STEP_W         = 10;
    localparam int TIME_W         = 16;
    localparam int THR_W          = 12;
    localparam int MISS_LIM_W     = 8;
    localparam int HOLD_W         = 17;
    localparam int MISS_W         = 9;
    localparam int PCT_W          = 7;
    localparam int TAG_W          = 2;
    localparam int PTS_W          = 4;
    localparam int NUM_W          = 23;
    localparam int DIV_STEPS      = 7;
    localparam int DIV_CNT_W      = 3;

    localparam logic [HOLD_W-1:0] HOLD_MAX   = '1;
    localparam logic [MISS_W-1:0] MISS_MAX   = '1;
    localparam logic [PTS_W-1:0]  MAX_POINTS = 4'd2;
    localparam logic [PCT_W-1:0]  PCT_FULL   = 7'd100;
    localparam logic [PCT_W-1:0]  PCT_SCALE  = 7'd100;

    localparam logic [STEP_W-1:0]     RST_HOLD_STEP  = 10'd50;
    localparam logic [TIME_W-1:0]     RST_WARN_TIME  = 16'd5000;
    localparam logic [TIME_W-1:0]     RST_RESET_TIME = 16'd7000;
    localparam logic [THR_W-1:0]      RST_Y_THR      = 12'd240;
    localparam logic [THR_W-1:0]      RST_ZONE_A_END = 12'd100;
    localparam logic [THR_W-1:0]      RST_ZONE_B_END = 12'd220;
    localparam logic [MISS_LIM_W-1:0] RST_MISS_LIMIT = 8'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOLD_STEP  = 3'd0,
        CFG_WARN_TIME  = 3'd1,
        CFG_RESET_TIME = 3'd2,
        CFG_Y_THR      = 3'd3,
        CFG_ZONE_A_END = 3'd4,
        CFG_ZONE_B_END = 3'd5,
        CFG_MISS_LIMIT = 3'd6
    } t_cfg_idx;

    typedef enum logic [TAG_W-1:0] {
        TAG_NONE   = 2'd0,
        TAG_ZONE_B = 2'd1,
        TAG_ZONE_C = 2'd2
    } t_tag;

    typedef struct packed {
        logic [STEP_W-1:0]     hold_step;
        logic [TIME_W-1:0]     warn_time;
        logic [TIME_W-1:0]     reset_time;
        logic [THR_W-1:0]      y_thr;
        logic [THR_W-1:0]      zone_a_end;
        logic [THR_W-1:0]      zone_b_end;
        logic [MISS_LIM_W-1:0] miss_limit;
    } t_cfg;

    typedef struct packed {
        logic                 load_in;
        logic                 eval;
        logic                 mul;
        logic                 div_step;
        logic [DIV_CNT_W-1:0] div_shift;
        logic                 out_load;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic out_free;
    } t_status;

endpackage

[rtl/tzhq_poll_if.sv]
`timescale 1ns / 1ps
// tzhq_poll_if: input channel carrying one controller poll per item
// depends on tzhq_pkg

interface tzhq_poll_if;
    import tzhq_pkg::*;

    logic              valid;
    logic              ready;
    logic              read_ok;
    logic [BYTE_W-1:0] status_byte;
    logic [BYTE_W-1:0] x_high_byte;
    logic [BYTE_W-1:0] x_low_byte;
    logic [BYTE_W-1:0] y_high_byte;
    logic [BYTE_W-1:0] y_low_byte;

    modport source (
        output valid, read_ok, status_byte, x_high_byte, x_low_byte,
        output y_high_byte, y_low_byte,
        input  ready
    );
    modport sink (
        input  valid, read_ok, status_byte, x_high_byte, x_low_byte,
        input  y_high_byte, y_low_byte,
        output ready
    );
endinterface

[rtl/tzhq_result_if.sv]
`timescale 1ns / 1ps
// tzhq_result_if: output channel carrying one qualified result per item
// depends on tzhq_pkg

interface tzhq_result_if;
    import tzhq_pkg::*;

    logic             valid;
    logic             ready;
    logic [TAG_W-1:0] tag;
    logic             tag_changed;
    logic             progress_update;
    logic [PCT_W-1:0] progress_percent;
    logic             progress_warn;
    logic             factory_reset;

    modport source (
        output valid, tag, tag_changed, progress_update, progress_percent,
        output progress_warn, factory_reset,
        input  ready
    );
    modport sink (
        input  valid, tag, tag_changed, progress_update, progress_percent,
        input  progress_warn, factory_reset,
        output ready
    );
endinterface

[rtl/touch_zone_hold_qualifier.sv]
`timescale 1ns / 1ps
// sequence: each poll is captured, evaluated and multiplied; for a zone-A hold below
// the reset time a 7-step restoring divider then forms the percent
// flow: a new poll is taken only after the last result has entered the result
// register, which waits on the sink while it is full
// reset: synchronous active-low; clears hold, miss count and tag state, loads the
// default configuration and empties the result register

module touch_zone_hold_qualifier #(
    parameter int COORD_BITS = tzhq_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tzhq_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tzhq_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    tzhq_poll_if.sink                       i_poll,
    tzhq_result_if.source                   o_result
);
    import tzhq_pkg::*;

    t_cfg    cfg;
    t_cmd    cmd;
    t_status status;

    tzhq_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    tzhq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_poll.valid),
        .o_in_ready (i_poll.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tzhq_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (cfg),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_read_ok          (i_poll.read_ok),
        .i_status_byte      (i_poll.status_byte),
        .i_x_high_byte      (i_poll.x_high_byte),
        .i_x_low_byte       (i_poll.x_low_byte),
        .i_y_high_byte      (i_poll.y_high_byte),
        .i_y_low_byte       (i_poll.y_low_byte),
        .o_valid            (o_result.valid),
        .i_ready            (o_result.ready),
        .o_tag              (o_result.tag),
        .o_tag_changed      (o_result.tag_changed),
        .o_progress_update  (o_result.progress_update),
        .o_progress_percent (o_result.progress_percent),
        .o_progress_warn    (o_result.progress_warn),
        .o_factory_reset    (o_result.factory_reset)
    );

endmodule

[rtl/tzhq_cfg_regs.sv]
`timescale 1ns / 1ps
// tzhq_cfg_regs: configuration register bank with write-only port
// depends on tzhq_pkg

module tzhq_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tzhq_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tzhq_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output tzhq_pkg::t_cfg                 o_cfg
);
    import tzhq_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_step  <= RST_HOLD_STEP;
            r_cfg.warn_time  <= RST_WARN_TIME;
            r_cfg.reset_time <= RST_RESET_TIME;
            r_cfg.y_thr      <= RST_Y_THR;
            r_cfg.zone_a_end <= RST_ZONE_A_END;
            r_cfg.zone_b_end <= RST_ZONE_B_END;
            r_cfg.miss_limit <= RST_MISS_LIMIT;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_HOLD_STEP:  r_cfg.hold_step  <= i_cfg_wdata[STEP_W-1:0];
                CFG_WARN_TIME:  r_cfg.warn_time  <= i_cfg_wdata[TIME_W-1:0];
                CFG_RESET_TIME: r_cfg.reset_time <= i_cfg_wdata[TIME_W-1:0];
                CFG_Y_THR:      r_cfg.y_thr      <= i_cfg_wdata[THR_W-1:0];
                CFG_ZONE_A_END: r_cfg.zone_a_end <= i_cfg_wdata[THR_W-1:0];
                CFG_ZONE_B_END: r_cfg.zone_b_end <= i_cfg_wdata[THR_W-1:0];
                CFG_MISS_LIMIT: r_cfg.miss_limit <= i_cfg_wdata[MISS_LIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/tzhq_ctrl.sv]
`timescale 1ns / 1ps
// tzhq_ctrl: sequencer for one poll: capture, evaluate, multiply, divide, deliver
// depends on tzhq_pkg

module tzhq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tzhq_pkg::t_status i_status,
    output tzhq_pkg::t_cmd    o_cmd
);
    import tzhq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EVAL = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    logic [DIV_CNT_W-1:0] r_bit, n_bit;

    always_comb begin
        n_state   = r_state;
        n_bit     = r_bit;
        o_cmd     = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_bit     = DIV_CNT_W'(DIV_STEPS - 1);
                n_state   = i_status.need_div ? S_DIV : S_DONE;
            end
            S_DIV: begin
                // one quotient bit per cycle, msb first
                o_cmd.div_step  = 1'b1;
                o_cmd.div_shift = r_bit;
                if (r_bit == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_bit   <= n_bit;
        end
    end

endmodule

[rtl/tzhq_datapath.sv]
`timescale 1ns / 1ps
// tzhq_datapath: poll decode, hold/miss/tag state, percent divider and output register
// depends on tzhq_pkg

module tzhq_datapath #(
    parameter int COORD_BITS = tzhq_pkg::COORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tzhq_pkg::t_cfg              i_cfg,
    input  tzhq_pkg::t_cmd              i_cmd,
    output tzhq_pkg::t_status           o_status,
    input  logic                        i_read_ok,
    input  logic [tzhq_pkg::BYTE_W-1:0] i_status_byte,
    input  logic [tzhq_pkg::BYTE_W-1:0] i_x_high_byte,
    input  logic [tzhq_pkg::BYTE_W-1:0] i_x_low_byte,
    input  logic [tzhq_pkg::BYTE_W-1:0] i_y_high_byte,
    input  logic [tzhq_pkg::BYTE_W-1:0] i_y_low_byte,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [tzhq_pkg::TAG_W-1:0]  o_tag,
    output logic                        o_tag_changed,
    output logic                        o_progress_update,
    output logic [tzhq_pkg::PCT_W-1:0]  o_progress_percent,
    output logic                        o_progress_warn,
    output logic                        o_factory_reset
);
    import tzhq_pkg::*;

    localparam int HI_W  = COORD_BITS - BYTE_W;
    localparam int CMP_W = (COORD_BITS > THR_W) ? COORD_BITS : THR_W;
    localparam logic [BYTE_W-1:0] HI_MASK = BYTE_W'((1 << HI_W) - 1);

    // captured poll
    logic              r_read_ok;
    logic [BYTE_W-1:0] r_status_byte, r_xh, r_xl, r_yh, r_yl;

    // block state
    logic [HOLD_W-1:0] r_hold;
    logic [MISS_W-1:0] r_miss;
    logic [TAG_W-1:0]  r_cur_tag;
    logic              r_rep_valid;

    // per-item results
    logic              r_upd, r_warn, r_fire, r_changed, r_need_div;
    logic [PCT_W-1:0]  r_pct;
    logic [TIME_W-1:0] r_num;
    logic [NUM_W-1:0]  r_rem;

    // output register
    logic             r_out_valid;
    logic [TAG_W-1:0] r_o_tag;
    logic             r_o_changed, r_o_upd, r_o_warn, r_o_fire;
    logic [PCT_W-1:0] r_o_pct;

    logic [COORD_BITS-1:0] x_coord, y_coord;
    logic [CMP_W-1:0]      x_c, y_c;
    logic [PTS_W-1:0]      pts;
    logic                  touched, in_zone_a, in_zone_b;
    logic [HOLD_W:0]       hold_sum;
    logic [HOLD_W-1:0]     hold_sat;
    logic                  reach_rt, reach_warn;
    logic [MISS_W-1:0]     miss_inc;
    logic                  released;

    logic [HOLD_W-1:0] e_hold;
    logic [MISS_W-1:0] e_miss;
    logic [TAG_W-1:0]  e_tag;
    logic              e_upd, e_warn, e_fire, e_need_div;
    logic [NUM_W-1:0]  trial;

    assign x_coord = COORD_BITS'({r_xh & HI_MASK, r_xl});
    assign y_coord = COORD_BITS'({r_yh & HI_MASK, r_yl});
    assign x_c     = CMP_W'(x_coord);
    assign y_c     = CMP_W'(y_coord);
    assign pts     = r_status_byte[PTS_W-1:0];

    assign touched   = r_read_ok && (pts != '0) && (pts <= MAX_POINTS)
                     && (y_c > CMP_W'(i_cfg.y_thr));
    assign in_zone_a = x_c < CMP_W'(i_cfg.zone_a_end);
    assign in_zone_b = x_c < CMP_W'(i_cfg.zone_b_end);

    assign hold_sum   = {1'b0, r_hold} + (HOLD_W + 1)'(i_cfg.hold_step);
    assign hold_sat   = hold_sum[HOLD_W] ? HOLD_MAX : hold_sum[HOLD_W-1:0];
    assign reach_rt   = hold_sat >= HOLD_W'(i_cfg.reset_time);
    assign reach_warn = hold_sat >= HOLD_W'(i_cfg.warn_time);
    assign miss_inc   = (r_miss != MISS_MAX) ? (r_miss + 1'b1) : r_miss;
    assign released   = miss_inc > MISS_W'(i_cfg.miss_limit);

    always_comb begin
        e_hold     = r_hold;
        e_miss     = r_miss;
        e_tag      = r_cur_tag;
        e_upd      = 1'b0;
        e_warn     = 1'b0;
        e_fire     = 1'b0;
        e_need_div = 1'b0;
        if (touched) begin
            e_miss = '0;
            if (in_zone_a) begin
                e_tag  = TAG_NONE;
                e_upd  = 1'b1;
                e_warn = reach_warn;
                if (reach_rt) begin
                    // percent is full at or past the reset time
                    e_fire = 1'b1;
                    e_hold = '0;
                end else begin
                    e_need_div = 1'b1;
                    e_hold     = hold_sat;
                end
            end else begin
                e_tag  = in_zone_b ? TAG_ZONE_B : TAG_ZONE_C;
                e_upd  = r_hold != '0;
                e_hold = '0;
            end
        end else begin
            e_miss = miss_inc;
            if (released) begin
                e_tag  = TAG_NONE;
                e_upd  = r_hold != '0;
                e_hold = '0;
            end
        end
    end

    assign trial = NUM_W'(i_cfg.reset_time) << i_cmd.div_shift;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_read_ok     <= i_read_ok;
            r_status_byte <= i_status_byte;
            r_xh          <= i_x_high_byte;
            r_xl          <= i_x_low_byte;
            r_yh          <= i_y_high_byte;
            r_yl          <= i_y_low_byte;
        end
        if (i_cmd.eval) begin
            r_upd      <= e_upd;
            r_warn     <= e_warn;
            r_fire     <= e_fire;
            r_need_div <= e_need_div;
            // reported tag always tracks the current tag after an item
            r_changed  <= !r_rep_valid || (e_tag != r_cur_tag);
            r_pct      <= e_fire ? PCT_FULL : '0;
            r_num      <= hold_sat[TIME_W-1:0];
        end
        if (i_cmd.mul && r_need_div) begin
            r_rem <= NUM_W'(32'(r_num) * 32'(PCT_SCALE));
            r_pct <= '0;
        end
        if (i_cmd.div_step && (r_rem >= trial)) begin
            r_rem                  <= r_rem - trial;
            r_pct[i_cmd.div_shift] <= 1'b1;
        end
        if (i_cmd.out_load) begin
            r_o_tag     <= r_cur_tag;
            r_o_changed <= r_changed;
            r_o_upd     <= r_upd;
            r_o_pct     <= r_pct;
            r_o_warn    <= r_warn;
            r_o_fire    <= r_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold      <= '0;
            r_miss      <= '0;
            r_cur_tag   <= TAG_NONE;
            r_rep_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.eval) begin
                r_hold      <= e_hold;
                r_miss      <= e_miss;
                r_cur_tag   <= e_tag;
                r_rep_valid <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.need_div = r_need_div;
    assign o_status.out_free = !r_out_valid || i_ready;

    assign o_valid            = r_out_valid;
    assign o_tag              = r_o_tag;
    assign o_tag_changed      = r_o_changed;
    assign o_progress_update  = r_o_upd;
    assign o_progress_percent = r_o_pct;
    assign o_progress_warn    = r_o_warn;
    assign o_factory_reset    = r_o_fire;

endmodule

[rtl/tzhq_checker.sv]
`timescale 1ns / 1ps
// tzhq_checker: port-level checks of the qualifier result stream, bound to the top level
// depends on tzhq_pkg and touch_zone_hold_qualifier

module tzhq_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [tzhq_pkg::TAG_W-1:0]    i_tag,
    input logic                          i_tag_changed,
    input logic                          i_progress_update,
    input logic [tzhq_pkg::PCT_W-1:0]    i_progress_percent,
    input logic                          i_progress_warn,
    input logic                          i_factory_reset
);
    import tzhq_pkg::*;

    // a stalled item keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_tag)
            && $stable(i_tag_changed) && $stable(i_progress_update)
            && $stable(i_progress_percent) && $stable(i_progress_warn)
            && $stable(i_factory_reset))
        else $error("result item changed while stalled");

    // a reset pulse comes only from a zone A hold, drawn full
    a_fire_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_factory_reset |->
            i_progress_update && (i_progress_percent == PCT_FULL) && (i_tag == TAG_NONE))
        else $error("factory reset without full progress");

    // no redraw means blank progress fields
    a_no_redraw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_progress_update |->
            (i_progress_percent == '0) && !i_progress_warn && !i_factory_reset)
        else $error("progress fields set without redraw");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_progress_percent <= PCT_FULL)
        else $error("progress percent above full");

endmodule

bind touch_zone_hold_qualifier tzhq_checker u_tzhq_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_out_valid        (o_result.valid),
    .i_out_ready        (o_result.ready),
    .i_tag              (o_result.tag),
    .i_tag_changed      (o_result.tag_changed),
    .i_progress_update  (o_result.progress_update),
    .i_progress_percent (o_result.progress_percent),
    .i_progress_warn    (o_result.progress_warn),
    .i_factory_reset    (o_result.factory_reset)
);

[sim/touch_zone_hold_qualifier_tb.sv]
`timescale 1ns / 1ps
// touch_zone_hold_qualifier_tb: self-checking bench, directed polls then random bursts per setting
// depends on tzhq_pkg, tzhq_poll_if, tzhq_result_if and touch_zone_hold_qualifier

module touch_zone_hold_qualifier_tb;
    import tzhq_pkg::*;

    typedef struct packed {
        logic              read_ok;
        logic [BYTE_W-1:0] status;
        logic [BYTE_W-1:0] x_hi;
        logic [BYTE_W-1:0] x_lo;
        logic [BYTE_W-1:0] y_hi;
        logic [BYTE_W-1:0] y_lo;
    } t_poll;

    typedef struct packed {
        t_tag             tag;
        logic             changed;
        logic             upd;
        logic [PCT_W-1:0] pct;
        logic             warn;
        logic             fire;
    } t_outcome;

    typedef struct packed {
        t_poll    poll;
        logic     typed;
        t_outcome want;
    } t_row;

    typedef enum logic [2:0] {
        BURST_ZONE_A,
        BURST_ZONE_B,
        BURST_ZONE_C,
        BURST_MISS,
        BURST_NOISE
    } t_burst;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    tzhq_poll_if   poll_ch ();
    tzhq_result_if result_ch ();

    touch_zone_hold_qualifier u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_poll      (poll_ch),
        .o_result    (result_ch)
    );

    always #4 i_clk = ~i_clk;

    // predictor state and configuration
    t_cfg              cfg;
    logic [HOLD_W-1:0] hold_ms;
    logic [MISS_W-1:0] miss_cnt;
    t_tag              cur_tag;
    t_tag              shown_tag;
    logic              shown_valid;

    t_outcome    expected_outcomes[$];
    t_row        dir_rows[$];
    int unsigned mismatches = 0;
    bit          quiet = 1'b0;
    int unsigned hold_off_cycles = 0;

    function automatic void reset_model();
        cfg.hold_step  = RST_HOLD_STEP;
        cfg.warn_time  = RST_WARN_TIME;
        cfg.reset_time = RST_RESET_TIME;
        cfg.y_thr      = RST_Y_THR;
        cfg.zone_a_end = RST_ZONE_A_END;
        cfg.zone_b_end = RST_ZONE_B_END;
        cfg.miss_limit = RST_MISS_LIMIT;
        hold_ms     = '0;
        miss_cnt    = '0;
        cur_tag     = TAG_NONE;
        shown_tag   = TAG_NONE;
        shown_valid = 1'b0;
    endfunction

    function automatic t_outcome qualify_poll(t_poll p);
        logic [THR_W-1:0]  x;
        logic [THR_W-1:0]  y;
        logic [HOLD_W:0]   sum;
        int unsigned       pct;
        bit                touched;
        bit                upd;
        bit                warn;
        bit                fire;
        t_outcome          r;
        touched = 1'b0;
        upd     = 1'b0;
        warn    = 1'b0;
        fire    = 1'b0;
        pct     = 0;
        x = {p.x_hi[COORD_BITS_DEF-9:0], p.x_lo};
        y = {p.y_hi[COORD_BITS_DEF-9:0], p.y_lo};
        if (p.read_ok && p.status[PTS_W-1:0] != '0 && p.status[PTS_W-1:0] <= MAX_POINTS
                && y > cfg.y_thr) begin
            touched  = 1'b1;
            miss_cnt = '0;
            if (x < cfg.zone_a_end) begin
                cur_tag = TAG_NONE;
                sum     = hold_ms + cfg.hold_step;
                hold_ms = (sum > HOLD_MAX) ? HOLD_MAX : sum[HOLD_W-1:0];
                upd     = 1'b1;
                warn    = hold_ms >= cfg.warn_time;
                if (cfg.reset_time == '0) begin
                    pct = 100;
                end else begin
                    pct = (int'(hold_ms) * 100) / int'(cfg.reset_time);
                    if (pct > 100) pct = 100;
                end
                if (hold_ms >= cfg.reset_time) begin
                    fire    = 1'b1;
                    hold_ms = '0;
                end
            end else begin
                cur_tag = (x < cfg.zone_b_end) ? TAG_ZONE_B : TAG_ZONE_C;
                if (hold_ms != '0) begin
                    hold_ms = '0;
                    upd     = 1'b1;
                end
            end
        end
        if (!touched) begin
            if (miss_cnt != MISS_MAX) miss_cnt = miss_cnt + 1'b1;
            // too many misses in a row: release the touch and abort any hold
            if (miss_cnt > cfg.miss_limit) begin
                cur_tag = TAG_NONE;
                if (hold_ms != '0) begin
                    hold_ms = '0;
                    upd     = 1'b1;
                    pct     = 0;
                    warn    = 1'b0;
                end
            end
        end
        r.changed   = !shown_valid || cur_tag != shown_tag;
        shown_tag   = cur_tag;
        shown_valid = 1'b1;
        r.tag  = cur_tag;
        r.upd  = upd;
        r.pct  = upd ? pct[PCT_W-1:0] : '0;
        r.warn = upd && warn;
        r.fire = fire;
        return r;
    endfunction

    function automatic void add_row(int unsigned ok, logic [7:0] st, logic [7:0] xh,
                                    logic [7:0] xl, logic [7:0] yh, logic [7:0] yl,
                                    int unsigned typed, t_tag tag, int unsigned changed,
                                    int unsigned upd, int unsigned pct);
        t_row row;
        row.poll      = '{1'(ok), st, xh, xl, yh, yl};
        row.typed     = 1'(typed);
        row.want      = '0;
        row.want.tag  = tag;
        row.want.changed = 1'(changed);
        row.want.upd  = 1'(upd);
        row.want.pct  = PCT_W'(pct);
        dir_rows.push_back(row);
    endfunction

    function automatic int unsigned pick(int unsigned lo, int unsigned hi);
        // lean on the range edges
        case ($urandom_range(0, 3))
            0: return lo;
            1: return hi;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    function automatic t_poll make_poll(t_burst kind);
        t_poll       p;
        int unsigned x;
        int unsigned y;
        int unsigned lo;
        p.read_ok = 1'b1;
        p.status  = {4'($urandom), 4'($urandom_range(1, 2))};
        x = $urandom_range(0, 4095);
        y = (cfg.y_thr != 12'hFFF) ? pick(int'(cfg.y_thr) + 1, 4095) : $urandom_range(0, 4095);
        case (kind)
            BURST_ZONE_A: begin
                if (cfg.zone_a_end != '0) x = pick(0, int'(cfg.zone_a_end) - 1);
            end
            BURST_ZONE_B: begin
                if (cfg.zone_a_end < cfg.zone_b_end)
                    x = pick(cfg.zone_a_end, int'(cfg.zone_b_end) - 1);
            end
            BURST_ZONE_C: begin
                lo = (cfg.zone_a_end > cfg.zone_b_end) ? cfg.zone_a_end : cfg.zone_b_end;
                x  = pick(lo, 4095);
            end
            BURST_MISS: begin
                case ($urandom_range(0, 3))
                    0: p.read_ok = 1'b0;
                    1: p.status[3:0] = 4'd0;
                    2: p.status[3:0] = 4'($urandom_range(3, 15));
                    default: y = pick(0, cfg.y_thr);
                endcase
            end
            default: ;
        endcase
        p.x_hi = {4'($urandom), x[11:8]};
        p.x_lo = x[7:0];
        p.y_hi = {4'($urandom), y[11:8]};
        p.y_lo = y[7:0];
        if (kind == BURST_NOISE) begin
            p.read_ok = 1'($urandom);
            p.status  = 8'($urandom);
            p.x_hi    = 8'($urandom);
            p.x_lo    = 8'($urandom);
            p.y_hi    = 8'($urandom);
            p.y_lo    = 8'($urandom);
        end
        return p;
    endfunction

    // called at a falling edge, returns at a falling edge with the item taken
    task automatic send_poll(t_poll p, bit typed, t_outcome want);
        int unsigned gap;
        t_outcome    got;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            poll_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        poll_ch.read_ok     = p.read_ok;
        poll_ch.status_byte = p.status;
        poll_ch.x_high_byte = p.x_hi;
        poll_ch.x_low_byte  = p.x_lo;
        poll_ch.y_high_byte = p.y_hi;
        poll_ch.y_low_byte  = p.y_lo;
        poll_ch.valid       = 1'b1;
        do @(posedge i_clk); while (!poll_ch.ready);
        got = qualify_poll(p);
        expected_outcomes.push_back(typed ? want : got);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        poll_ch.valid = 1'b0;
        while (expected_outcomes.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] v);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = v;
        case (idx)
            CFG_HOLD_STEP:  cfg.hold_step  = v[STEP_W-1:0];
            CFG_WARN_TIME:  cfg.warn_time  = v;
            CFG_RESET_TIME: cfg.reset_time = v;
            CFG_Y_THR:      cfg.y_thr      = v[THR_W-1:0];
            CFG_ZONE_A_END: cfg.zone_a_end = v[THR_W-1:0];
            CFG_ZONE_B_END: cfg.zone_b_end = v[THR_W-1:0];
            CFG_MISS_LIMIT: cfg.miss_limit = v[MISS_LIM_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic apply_setting(int unsigned step, int unsigned warn, int unsigned rst_time,
                                 int unsigned ythr, int unsigned a_end, int unsigned b_end,
                                 int unsigned limit);
        drain_results();
        write_reg(CFG_HOLD_STEP, CFG_DATA_W'(step));
        write_reg(CFG_WARN_TIME, CFG_DATA_W'(warn));
        write_reg(CFG_RESET_TIME, CFG_DATA_W'(rst_time));
        write_reg(CFG_Y_THR, CFG_DATA_W'(ythr));
        write_reg(CFG_ZONE_A_END, CFG_DATA_W'(a_end));
        write_reg(CFG_ZONE_B_END, CFG_DATA_W'(b_end));
        write_reg(CFG_MISS_LIMIT, CFG_DATA_W'(limit));
        i_cfg_we = 1'b0;
    endtask

    task automatic run_random(int unsigned count);
        int unsigned sent;
        int unsigned run_len;
        int unsigned r;
        t_burst      kind;
        sent = 0;
        while (sent < count) begin
            r = $urandom_range(0, 99);
            if (r < 55)      kind = BURST_ZONE_A;
            else if (r < 65) kind = BURST_ZONE_B;
            else if (r < 75) kind = BURST_ZONE_C;
            else if (r < 92) kind = BURST_MISS;
            else             kind = BURST_NOISE;
            run_len = (kind == BURST_ZONE_A) ? $urandom_range(1, 40) : $urandom_range(1, 8);
            quiet = ($urandom_range(0, 5) == 0);
            repeat (run_len) begin
                if (sent < count) begin
                    send_poll(make_poll(kind), 1'b0, '0);
                    sent++;
                end
            end
        end
        quiet = 1'b0;
    endtask

    function automatic void check_field(string what, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected %0d got %0d", $time, what, want, got);
        end
    endfunction

    // result side
    initial begin
        t_outcome    want;
        int unsigned stall;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles != 0) begin
                result_ch.ready = 1'b0;
                repeat (hold_off_cycles) @(negedge i_clk);
                hold_off_cycles = 0;
            end
            stall = quiet ? 0 : $urandom_range(0, 3);
            if (stall != 0) begin
                result_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            result_ch.ready = 1'b1;
            do @(posedge i_clk); while (!result_ch.valid);
            if (expected_outcomes.size() == 0) begin
                mismatches++;
                $display("%0t: result with no poll pending, tag %0d", $time, result_ch.tag);
            end else begin
                want = expected_outcomes.pop_front();
                check_field("tag", want.tag, result_ch.tag);
                check_field("tag_changed", want.changed, result_ch.tag_changed);
                check_field("progress_update", want.upd, result_ch.progress_update);
                check_field("progress_percent", want.pct, result_ch.progress_percent);
                check_field("progress_warn", want.warn, result_ch.progress_warn);
                check_field("factory_reset", want.fire, result_ch.factory_reset);
            end
        end
    end

    initial begin
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = CFG_HOLD_STEP;
        i_cfg_wdata           = '0;
        poll_ch.valid         = 1'b0;
        poll_ch.read_ok       = 1'b0;
        poll_ch.status_byte   = '0;
        poll_ch.x_high_byte   = '0;
        poll_ch.x_low_byte    = '0;
        poll_ch.y_high_byte   = '0;
        poll_ch.y_low_byte    = '0;
        result_ch.ready       = 1'b0;
        reset_model();

        // default setting: A below x 100, B below 220, y must exceed 240, 5 misses allowed
        add_row(0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1, TAG_NONE,   1, 0, 0);  // first poll reports
        add_row(1, 8'h01, 8'h00, 8'h00, 8'h00, 8'hF1, 0, TAG_NONE,   0, 0, 0);
        add_row(1, 8'h02, 8'hF0, 8'h63, 8'hF0, 8'hF1, 0, TAG_NONE,   0, 0, 0);  // upper nibbles masked
        add_row(1, 8'h01, 8'h00, 8'h64, 8'h00, 8'hF1, 1, TAG_ZONE_B, 1, 1, 0);  // hold cancelled
        add_row(1, 8'h01, 8'h00, 8'hDB, 8'h00, 8'hF1, 1, TAG_ZONE_B, 0, 0, 0);
        add_row(1, 8'h02, 8'h00, 8'hDC, 8'h00, 8'hF1, 1, TAG_ZONE_C, 1, 0, 0);
        add_row(1, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, TAG_ZONE_C, 0, 0, 0);
        add_row(1, 8'h01, 8'h00, 8'h32, 8'h00, 8'hF0, 1, TAG_ZONE_C, 0, 0, 0);  // y on threshold
        add_row(1, 8'h00, 8'h00, 8'h32, 8'h00, 8'hF1, 1, TAG_ZONE_C, 0, 0, 0);  // no points
        add_row(1, 8'h03, 8'h00, 8'h32, 8'h00, 8'hF1, 1, TAG_ZONE_C, 0, 0, 0);  // three points
        add_row(1, 8'hF1, 8'h00, 8'h96, 8'h00, 8'hF1, 1, TAG_ZONE_B, 1, 0, 0);
        repeat (3) add_row(0, 8'h01, 8'h00, 8'hDC, 8'h00, 8'hF1, 1, TAG_ZONE_B, 0, 0, 0);
        repeat (2) add_row(0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, TAG_ZONE_B, 0, 0, 0);
        add_row(0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, TAG_NONE,   1, 0, 0);  // released
        add_row(1, 8'h01, 8'h00, 8'h00, 8'h00, 8'hF1, 1, TAG_NONE,   0, 1, 0);
        repeat (5) add_row(1, 8'h0F, 8'h00, 8'h00, 8'h00, 8'hF1, 1, TAG_NONE, 0, 0, 0);
        add_row(1, 8'h0F, 8'h00, 8'h00, 8'h00, 8'hF1, 1, TAG_NONE,   0, 1, 0);  // hold aborted

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[k]) send_poll(dir_rows[k].poll, dir_rows[k].typed, dir_rows[k].want);

        apply_setting(50, 5000, 7000, 240, 100, 220, 5);
        run_random(180);
        apply_setting(1000, 0, 1, 0, 4095, 4095, 0);       // fires on every zone A poll
        run_random(150);
        apply_setting(1, 65535, 65535, 4094, 0, 4095, 255);
        run_random(120);
        apply_setting(300, 2000, 3000, 100, 2048, 3000, 3);
        hold_off_cycles = 80;                              // let the block back up
        run_random(200);
        apply_setting(137, 900, 1000, 0, 1000, 500, 1);    // zone b end below zone a end
        run_random(150);
        apply_setting(10, 0, 0, 200, 3000, 3500, 2);       // reset time zero
        run_random(120);
        apply_setting(1000, 65535, 65535, 0, 4095, 0, 255);
        run_random(150);
        apply_setting($urandom_range(1, 1000), $urandom_range(0, 8000), $urandom_range(1, 8000),
                      $urandom_range(0, 3000), $urandom_range(0, 4095), $urandom_range(0, 4095),
                      $urandom_range(0, 20));
        run_random(200);

        drain_results();
        repeat (16) @(posedge i_clk);
        if (mismatches == 0 && expected_outcomes.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/tzhq_pkg.sv
rtl/tzhq_poll_if.sv
rtl/tzhq_result_if.sv
rtl/tzhq_cfg_regs.sv
rtl/tzhq_ctrl.sv
rtl/tzhq_datapath.sv
rtl/touch_zone_hold_qualifier.sv
rtl/tzhq_checker.sv
sim/touch_zone_hold_qualifier_tb.sv
